>>> sv/arm_instruction_flow_classifier_core_defines.svh
// Assertion macros shared by the flow classifier RTL.
`ifndef ARM_INSTRUCTION_FLOW_CLASSIFIER_CORE_DEFINES_SVH
`define ARM_INSTRUCTION_FLOW_CLASSIFIER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define AIFC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define AIFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/aifc_pkg.sv
// Types and constants of the ARM instruction flow classifier.
package aifc_pkg;

    // Control-flow class codes.
    typedef enum logic [3:0] {
        FC_LINEAR = 4'd0,
        FC_LOAD   = 4'd1,
        FC_STORE  = 4'd2,
        FC_STACK  = 4'd3,
        FC_CASE   = 4'd4,
        FC_RET    = 4'd5,
        FC_CRET   = 4'd6,
        FC_BR     = 4'd7,
        FC_CBR    = 4'd8,
        FC_CALLR  = 4'd9,
        FC_CCALLR = 4'd10,
        FC_B      = 4'd11,
        FC_CB     = 4'd12,
        FC_CALL   = 4'd13,
        FC_CCALL  = 4'd14,
        FC_UNDEF  = 4'd15
    } t_flow_class;

    // Register select (bit 3 of the byte address).
    localparam logic REG_IMAGE_BASE   = 1'b0;
    localparam logic REG_IMAGE_LENGTH = 1'b1;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 64;

    // Encoding masks and patterns.
    localparam logic [31:0] MASK_CASE    = 32'h0fff_fff0;
    localparam logic [31:0] PAT_CASE     = 32'h008f_f100;
    localparam logic [31:0] MASK_FULL    = 32'h0fff_ffff;
    localparam logic [31:0] PAT_BX_LR    = 32'h012f_ff1e;
    localparam logic [31:0] PAT_MOV_LR   = 32'h01a0_f00e;
    localparam logic [31:0] PAT_MOV_REG  = 32'h01a0_f000;
    localparam logic [31:0] MASK_IMM_PC  = 32'h0f3f_f000;
    localparam logic [31:0] PAT_IMM_PC   = 32'h020f_f000;
    localparam logic [31:0] MASK_MSR_UND = 32'h0fb0_0000;
    localparam logic [31:0] PAT_MSR_UND  = 32'h0300_0000;
    localparam logic [31:0] MASK_POP_PC  = 32'h0fff_f000;
    localparam logic [31:0] PAT_POP_PC   = 32'h049d_f000;
    localparam logic [31:0] MASK_LIT_PC  = 32'h0f7f_f000;
    localparam logic [31:0] PAT_LIT_PC   = 32'h051f_f000;

    // Input transaction.
    typedef struct packed {
        logic [31:0] instr_word;
        logic [31:0] instr_address;
    } t_instr_in;

    // Result transaction.
    typedef struct packed {
        t_flow_class flow_class;
        logic [31:0] target;
        logic        target_valid;
        logic        target_is_pool;
    } t_flow_out;

endpackage

>>> sv/arm_instruction_flow_classifier_core.sv
// Top level: three-stage pipelined ARM control-flow classifier with APB registers.
//
//  Channel   Signals                                   Direction
//  --------  ----------------------------------------  ---------
//  in        i_in_valid / o_in_ready / i_in_data       into block
//  out       o_out_valid / i_out_ready / o_out_data    out of block
//  config    psel penable pwrite paddr pwdata prdata   APB slave
//
// One instruction is accepted every cycle unless a full pipeline is held by a
// stalled output: stage 1 checks the image bounds, stage 2 decodes, stage 3 adds
// the branch or pool offset into the output register.
// Reset clears the stage valid bits and both registers to zero.
// A stalled output stage holds; upstream stages keep filling their empty slots.
// Registers sit at byte addresses 0 (image_base) and 8 (image_length); only
// address bit 3 is decoded.
`include "arm_instruction_flow_classifier_core_defines.svh"

module arm_instruction_flow_classifier_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  aifc_pkg::t_instr_in                 i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output aifc_pkg::t_flow_out                 o_out_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [aifc_pkg::PADDR_W-1:0]        paddr,
    input  logic [aifc_pkg::PDATA_W-1:0]        pwdata,
    output logic [aifc_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);

    // Configuration registers.
    logic [31:0] r_image_base;
    logic [32:0] r_image_length;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_base   <= '0;
            r_image_length <= '0;
        end else if (cfg_wr) begin
            case (paddr[3])
                aifc_pkg::REG_IMAGE_BASE:   r_image_base   <= pwdata[31:0];
                aifc_pkg::REG_IMAGE_LENGTH: r_image_length <= pwdata[32:0];
                default:                    r_image_base   <= r_image_base;
            endcase
        end
    end

    // Register read data.
    always_comb begin
        case (paddr[3])
            aifc_pkg::REG_IMAGE_BASE:   prdata = {32'd0, r_image_base};
            aifc_pkg::REG_IMAGE_LENGTH: prdata = {31'd0, r_image_length};
            default:                    prdata = '0;
        endcase
    end

    // Stage handshake: a stage loads when it is empty or its contents move on.
    logic r_v1, r_v2, r_v3;
    logic rdy1, rdy2, rdy3;

    assign rdy3       = !r_v3 || i_out_ready;
    assign rdy2       = !r_v2 || rdy3;
    assign rdy1       = !r_v1 || rdy2;
    assign o_in_ready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_in_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
        end
    end

    // Stage 1: image bounds and alignment of the instruction address.
    logic [33:0] s1_addr_ext;
    logic [33:0] s1_limit;
    logic        n_ok;
    logic [31:0] r_w1;
    logic [31:0] r_pc1;
    logic        r_ok1;

    assign s1_addr_ext = {2'b00, i_in_data.instr_address};
    assign s1_limit    = {2'b00, r_image_base} + {1'b0, r_image_length};
    assign n_ok = (s1_addr_ext >= {2'b00, r_image_base})
               && ((s1_addr_ext + 34'd1) < s1_limit)
               && (i_in_data.instr_address[1:0] == 2'b00);

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_w1  <= i_in_data.instr_word;
            r_pc1 <= i_in_data.instr_address;
            r_ok1 <= n_ok;
        end
    end

    // Stage 2: instruction decode and offset selection.
    logic [31:0]          w;
    logic                 unc;
    logic [2:0]           icls;
    logic [3:0]           opc;
    logic                 sl, b4, b7, b15, b24, up, cond_nv;
    logic [3:0]           rn, rd, rm;
    logic [31:0]          lit_off;
    aifc_pkg::t_flow_class n_cls;
    logic [31:0]          n_off;
    logic                 n_tv, n_pool, n_blx;

    assign w       = r_w1;
    assign unc     = (w[31:29] == 3'b111);
    assign cond_nv = (w[31:28] == 4'hf);
    assign icls    = w[27:25];
    assign opc     = w[24:21];
    assign rn      = w[19:16];
    assign rd      = w[15:12];
    assign rm      = w[3:0];
    assign sl      = w[20];
    assign up      = w[23];
    assign b4      = w[4];
    assign b7      = w[7];
    assign b15     = w[15];
    assign b24     = w[24];
    assign lit_off = up ? {20'd0, w[11:0]} : (32'd0 - {20'd0, w[11:0]});

    always_comb begin
        n_cls  = aifc_pkg::FC_LINEAR;
        n_off  = '0;
        n_tv   = 1'b0;
        n_pool = 1'b0;
        n_blx  = 1'b0;
        if (!r_ok1) begin
            n_cls = aifc_pkg::FC_UNDEF;
        end else if ((w & aifc_pkg::MASK_CASE) == aifc_pkg::PAT_CASE) begin
            n_cls = aifc_pkg::FC_CASE;
        end else if (((w & aifc_pkg::MASK_FULL) == aifc_pkg::PAT_BX_LR)
                  || ((w & aifc_pkg::MASK_FULL) == aifc_pkg::PAT_MOV_LR)) begin
            n_cls = unc ? aifc_pkg::FC_RET : aifc_pkg::FC_CRET;
        end else if (((w & aifc_pkg::MASK_CASE) == aifc_pkg::PAT_MOV_REG)
                  || ((w & aifc_pkg::MASK_IMM_PC) == aifc_pkg::PAT_IMM_PC)) begin
            n_cls = unc ? aifc_pkg::FC_BR : aifc_pkg::FC_CBR;
        end else if (icls == 3'd0 && !sl && opc[3:2] == 2'b10 && (!b4 || !b7)) begin
            // Miscellaneous space: BX, BLX register, everything else is linear.
            if (w[22:21] == 2'd1 && w[7:4] == 4'd1) begin
                if (rm == 4'he) n_cls = unc ? aifc_pkg::FC_RET : aifc_pkg::FC_CRET;
                else            n_cls = unc ? aifc_pkg::FC_BR : aifc_pkg::FC_CBR;
            end else if (w[22:21] == 2'd1 && w[7:4] == 4'd3) begin
                n_cls = unc ? aifc_pkg::FC_CALLR : aifc_pkg::FC_CCALLR;
            end
        end else if (icls == 3'd0 && b4 && b7) begin
            n_cls = aifc_pkg::FC_LINEAR;
        end else if (icls == 3'd0) begin
            if (rd == 4'hf) n_cls = unc ? aifc_pkg::FC_BR : aifc_pkg::FC_CBR;
        end else if ((w & aifc_pkg::MASK_MSR_UND) == aifc_pkg::PAT_MSR_UND) begin
            n_cls = aifc_pkg::FC_UNDEF;
        end else if (icls == 3'd1 && (opc & 4'hd) == 4'h9 && !sl && rd == 4'hf) begin
            n_cls = aifc_pkg::FC_LINEAR;
        end else if (icls == 3'd1) begin
            // A conditional immediate write to pc stays linear.
            if (rd == 4'hf && unc) n_cls = aifc_pkg::FC_BR;
        end else if (icls == 3'd3 && b4) begin
            n_cls = aifc_pkg::FC_UNDEF;
        end else if (w[31:27] == 5'b11110) begin
            n_cls = aifc_pkg::FC_UNDEF;
        end else if (icls == 3'd4 && cond_nv) begin
            n_cls = aifc_pkg::FC_UNDEF;
        end else if ((w & aifc_pkg::MASK_POP_PC) == aifc_pkg::PAT_POP_PC) begin
            n_cls = unc ? aifc_pkg::FC_RET : aifc_pkg::FC_CRET;
        end else if ((w & aifc_pkg::MASK_LIT_PC) == aifc_pkg::PAT_LIT_PC) begin
            // Literal-pool load into pc; the address is aligned, so the offset
            // alone decides pool alignment.
            if (lit_off[1:0] != 2'b00) begin
                n_cls = aifc_pkg::FC_UNDEF;
            end else begin
                n_cls  = unc ? aifc_pkg::FC_B : aifc_pkg::FC_CB;
                n_off  = lit_off;
                n_tv   = 1'b1;
                n_pool = 1'b1;
            end
        end else if (icls == 3'd2 || icls == 3'd3) begin
            if (rd == 4'hf)      n_cls = unc ? aifc_pkg::FC_BR : aifc_pkg::FC_CBR;
            else if (rn == 4'hd) n_cls = aifc_pkg::FC_LINEAR;
            else                 n_cls = sl ? aifc_pkg::FC_LOAD : aifc_pkg::FC_STORE;
        end else if (icls == 3'd4 && sl && b15) begin
            n_cls = unc ? aifc_pkg::FC_RET : aifc_pkg::FC_CRET;
        end else if (icls == 3'd4) begin
            if (rn == 4'hd) n_cls = aifc_pkg::FC_STACK;
            else            n_cls = sl ? aifc_pkg::FC_LOAD : aifc_pkg::FC_STORE;
        end else if (icls == 3'd5) begin
            // Direct branch: 24-bit word offset, halfword bit for BLX.
            n_off = {{6{w[23]}}, w[23:0], (cond_nv & b24), 1'b0};
            n_tv  = 1'b1;
            if (cond_nv) begin
                n_cls = aifc_pkg::FC_CALL;
                n_blx = 1'b1;
            end else if (!b24) begin
                n_cls = unc ? aifc_pkg::FC_B : aifc_pkg::FC_CB;
            end else begin
                n_cls = unc ? aifc_pkg::FC_CALL : aifc_pkg::FC_CCALL;
            end
        end else if (w[31:24] == 8'hff) begin
            n_cls = aifc_pkg::FC_UNDEF;
        end
    end

    aifc_pkg::t_flow_class r_cls2;
    logic [31:0]           r_off2;
    logic [31:0]           r_pc8;
    logic                  r_tv2, r_pool2, r_blx2;

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_cls2  <= n_cls;
            r_off2  <= n_off;
            r_pc8   <= r_pc1 + 32'd8;
            r_tv2   <= n_tv;
            r_pool2 <= n_pool;
            r_blx2  <= n_blx;
        end
    end

    // Stage 3: target add into the output register.
    aifc_pkg::t_flow_out n_out;
    aifc_pkg::t_flow_out r_out;

    always_comb begin
        n_out.flow_class     = r_cls2;
        n_out.target_valid   = r_tv2;
        n_out.target_is_pool = r_pool2;
        n_out.target         = '0;
        if (r_tv2) begin
            n_out.target = (r_pc8 + r_off2) | {31'd0, r_blx2};
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_v3;
    assign o_out_data  = r_out;

    // Checks on the pipeline and the result encoding.
    `AIFC_ASSERT_SAME(a_pool_has_target, i_clk, i_rst_n,
        o_out_valid && o_out_data.target_is_pool, o_out_data.target_valid,
        "Pool flag without a valid target.")
    `AIFC_ASSERT_SAME(a_pool_aligned, i_clk, i_rst_n,
        o_out_valid && o_out_data.target_is_pool, o_out_data.target[1:0] == 2'b00,
        "Literal-pool address is not word aligned.")
    `AIFC_ASSERT_SAME(a_target_class, i_clk, i_rst_n,
        o_out_valid && o_out_data.target_valid,
        (o_out_data.flow_class == aifc_pkg::FC_B) || (o_out_data.flow_class == aifc_pkg::FC_CB)
        || (o_out_data.flow_class == aifc_pkg::FC_CALL)
        || (o_out_data.flow_class == aifc_pkg::FC_CCALL),
        "Target given for a class without a direct destination.")
    `AIFC_ASSERT_NEXT(a_stage2_holds, i_clk, i_rst_n,
        r_v2 && r_v3 && !i_out_ready, r_v2 && $stable(r_cls2) && $stable(r_off2),
        "Decode stage changed while the output stage was stalled.")
    `AIFC_ASSERT_NEXT(a_accept_fills, i_clk, i_rst_n,
        i_in_valid && o_in_ready, r_v1,
        "Accepted transaction did not enter the first stage.")

endmodule
